>>> hdl/tnas_pkg.sv
// Shared types, constants and frame tables for the neighbour autotile selector.
package tnas_pkg;

	// Field widths
	localparam int ID_BITS    = 16;
	localparam int COORD_BITS = 12;
	localparam int DIM_BITS   = 13;
	localparam int MODE_BITS  = 2;
	localparam int FRAME_BITS = 6;
	localparam int CFG_BITS   = 13;
	localparam int INDEX_BITS = 2;

	// Register indexes
	localparam logic [INDEX_BITS-1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_TILE_MODE  = 2'd2;

	// Tile modes
	localparam logic [MODE_BITS-1:0] MODE_TABLE_A = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_TABLE_B = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_BLOB    = 2'd2;

	// Reset values
	localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 13'd64;
	localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 13'd64;
	localparam logic [MODE_BITS-1:0] MODE_RESET   = MODE_BLOB;

	// Neighbour slots, ordered NW, N, NE, W, E, SW, S, SE
	localparam int NB_NW = 0;
	localparam int NB_N  = 1;
	localparam int NB_NE = 2;
	localparam int NB_W  = 3;
	localparam int NB_E  = 4;
	localparam int NB_SW = 5;
	localparam int NB_S  = 6;
	localparam int NB_SE = 7;

	typedef struct packed {
		logic [DIM_BITS-1:0]  map_width;
		logic [DIM_BITS-1:0]  map_height;
		logic [MODE_BITS-1:0] tile_mode;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]        tile_x;
		logic [COORD_BITS-1:0]        tile_y;
		logic [ID_BITS-1:0]           center_id;
		logic [7:0][ID_BITS-1:0]      nbr_id;
	} item_t;

	// Four-neighbour tables, mask is {N, W, S, E}
	localparam logic [FRAME_BITS-1:0] TABLE_A [16] = '{
		6'd4, 6'd4, 6'd4, 6'd0, 6'd4, 6'd4, 6'd2, 6'd1,
		6'd4, 6'd6, 6'd4, 6'd3, 6'd8, 6'd7, 6'd5, 6'd4
	};
	localparam logic [FRAME_BITS-1:0] TABLE_B [16] = '{
		6'd15, 6'd12, 6'd3,  6'd0, 6'd14, 6'd13, 6'd2, 6'd1,
		6'd11, 6'd8,  6'd7,  6'd4, 6'd10, 6'd9,  6'd6, 6'd5
	};

	// 48-frame blob table; patterns not listed give frame 0
	function automatic logic [FRAME_BITS-1:0] blob_frame(input logic [7:0] pattern);
		logic [FRAME_BITS-1:0] f;
		case (pattern)
			8'h02: f = 6'd0;
			8'h0A: f = 6'd1;
			8'h1A: f = 6'd2;
			8'h12: f = 6'd3;
			8'hDA: f = 6'd4;
			8'h1B: f = 6'd5;
			8'h1E: f = 6'd6;
			8'h7A: f = 6'd7;
			8'h0B: f = 6'd8;
			8'h5F: f = 6'd9;
			8'h1F: f = 6'd10;
			8'h16: f = 6'd11;
			8'h42: f = 6'd12;
			8'h4A: f = 6'd13;
			8'h5A: f = 6'd14;
			8'h52: f = 6'd15;
			8'h4B: f = 6'd16;
			8'h7F: f = 6'd17;
			8'hDF: f = 6'd18;
			8'h56: f = 6'd19;
			8'h6B: f = 6'd20;
			8'h7E: f = 6'd21;
			8'h80: f = 6'd22;
			8'hDE: f = 6'd23;
			8'h40: f = 6'd24;
			8'h48: f = 6'd25;
			8'h58: f = 6'd26;
			8'h50: f = 6'd27;
			8'h6A: f = 6'd28;
			8'hFB: f = 6'd29;
			8'hFE: f = 6'd30;
			8'hD2: f = 6'd31;
			8'h7B: f = 6'd32;
			8'hFF: f = 6'd33;
			8'hDB: f = 6'd34;
			8'hD6: f = 6'd35;
			8'h00: f = 6'd36;
			8'h08: f = 6'd37;
			8'h18: f = 6'd38;
			8'h10: f = 6'd39;
			8'h5E: f = 6'd40;
			8'h78: f = 6'd41;
			8'hD8: f = 6'd42;
			8'h5B: f = 6'd43;
			8'h68: f = 6'd44;
			8'hF8: f = 6'd45;
			8'hFA: f = 6'd46;
			8'hD0: f = 6'd47;
			default: f = 6'd0;
		endcase
		return f;
	endfunction

endpackage

>>> hdl/tnas_classify.sv
// Combinational frame classifier: neighbour matching, edge gating and table lookup.
module tnas_classify
	import tnas_pkg::*;
(
	input  cfg_t                  cfg,
	input  item_t                 item,
	output logic [FRAME_BITS-1:0] frame_index
);

	logic [DIM_BITS-1:0] x_ext, y_ext, x_inc, y_inc;
	logic                col_lo_ok, col_mid_ok, col_hi_ok;
	logic                row_lo_ok, row_mid_ok, row_hi_ok;
	logic                h_inner, v_inner;
	logic [7:0]          eq;
	logic [7:0]          col_ok, row_ok;
	logic [7:0]          raw_m, blob_m;
	logic [3:0]          quad_m;

	// Compare every neighbour against the tile's own id
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			eq[i] = (item.nbr_id[i] == item.center_id);
		end
	end

	// Column and row checks against the map size
	assign x_ext = {1'b0, item.tile_x};
	assign y_ext = {1'b0, item.tile_y};
	assign x_inc = x_ext + 13'd1;
	assign y_inc = y_ext + 13'd1;

	assign col_lo_ok  = (item.tile_x != '0) && (x_ext <= cfg.map_width);
	assign col_mid_ok = (x_ext < cfg.map_width);
	assign col_hi_ok  = (x_inc < cfg.map_width);
	assign row_lo_ok  = (item.tile_y != '0) && (y_ext <= cfg.map_height);
	assign row_mid_ok = (y_ext < cfg.map_height);
	assign row_hi_ok  = (y_inc < cfg.map_height);

	// Strictly inside the map on that axis (edge tiles never join in four-neighbour modes)
	assign h_inner = (item.tile_x != '0) && col_hi_ok;
	assign v_inner = (item.tile_y != '0) && row_hi_ok;

	assign col_ok = {col_lo_ok, col_mid_ok, col_hi_ok, col_lo_ok,
	                 col_hi_ok, col_lo_ok, col_mid_ok, col_hi_ok};
	assign row_ok = {row_lo_ok, row_lo_ok, row_lo_ok, row_mid_ok,
	                 row_mid_ok, row_hi_ok, row_hi_ok, row_hi_ok};

	// Build the eight-neighbour byte, NW in bit 7 down to SE in bit 0
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			raw_m[7-i] = eq[i] && col_ok[7-i] && row_ok[7-i];
		end
	end

	// Drop a corner unless both adjoining edges match
	always_comb begin
		blob_m    = raw_m;
		blob_m[7] = raw_m[7] & raw_m[6] & raw_m[4];
		blob_m[5] = raw_m[5] & raw_m[6] & raw_m[3];
		blob_m[2] = raw_m[2] & raw_m[4] & raw_m[1];
		blob_m[0] = raw_m[0] & raw_m[1] & raw_m[3];
	end

	// Four-neighbour mask: N bit 3, W bit 2, S bit 1, E bit 0
	assign quad_m = {v_inner & eq[NB_N], h_inner & eq[NB_W],
	                 v_inner & eq[NB_S], h_inner & eq[NB_E]};

	// Select the active table
	always_comb begin
		case (cfg.tile_mode)
			MODE_TABLE_A: frame_index = TABLE_A[quad_m];
			MODE_TABLE_B: frame_index = TABLE_B[quad_m];
			MODE_BLOB:    frame_index = blob_frame(blob_m);
			default:      frame_index = '0;
		endcase
	end

endmodule

>>> hdl/tile_neighbour_autotile_select_top.sv
// Top level of the neighbour autotile selector: registers, handshake and pipeline.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    tile_x, tile_y, center_id, eight neighbour ids
//  out      output     out_valid / out_stall  frame_index
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes the input register,
// then the classifier logic into the result register.
// Reset clears both valid flags and loads width 64, height 64, eight-neighbour mode.
// A stall on the output holds the result register; the input register keeps
// accepting until it too is full, so in_stall rises only once it holds an item as well.
module tile_neighbour_autotile_select_top
	import tnas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] tile_x,
	input  logic [COORD_BITS-1:0] tile_y,
	input  logic [ID_BITS-1:0]    center_id,
	input  logic [ID_BITS-1:0]    northwest_id,
	input  logic [ID_BITS-1:0]    north_id,
	input  logic [ID_BITS-1:0]    northeast_id,
	input  logic [ID_BITS-1:0]    west_id,
	input  logic [ID_BITS-1:0]    east_id,
	input  logic [ID_BITS-1:0]    southwest_id,
	input  logic [ID_BITS-1:0]    south_id,
	input  logic [ID_BITS-1:0]    southeast_id,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FRAME_BITS-1:0] frame_index
);

	cfg_t                  cfg_q;
	item_t                 item_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic [FRAME_BITS-1:0] frame_s2;
	logic [FRAME_BITS-1:0] frame_next;
	logic                  adv_s2;
	logic                  adv_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width  <= WIDTH_RESET;
			cfg_q.map_height <= HEIGHT_RESET;
			cfg_q.tile_mode  <= MODE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_WIDTH:  cfg_q.map_width  <= cfg_data;
				REG_MAP_HEIGHT: cfg_q.map_height <= cfg_data;
				REG_TILE_MODE:  cfg_q.tile_mode  <= cfg_data[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow: result stage moves when empty or drained, input stage when empty or it can pass on
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1.tile_x            <= tile_x;
			item_s1.tile_y            <= tile_y;
			item_s1.center_id         <= center_id;
			item_s1.nbr_id[NB_NW]     <= northwest_id;
			item_s1.nbr_id[NB_N]      <= north_id;
			item_s1.nbr_id[NB_NE]     <= northeast_id;
			item_s1.nbr_id[NB_W]      <= west_id;
			item_s1.nbr_id[NB_E]      <= east_id;
			item_s1.nbr_id[NB_SW]     <= southwest_id;
			item_s1.nbr_id[NB_S]      <= south_id;
			item_s1.nbr_id[NB_SE]     <= southeast_id;
		end
	end

	tnas_classify u_classify (
		.cfg         (cfg_q),
		.item        (item_s1),
		.frame_index (frame_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			frame_s2 <= frame_next;
		end
	end

	assign out_valid   = valid_s2;
	assign frame_index = frame_s2;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the neighbour autotile frame selector.
`timescale 1ns / 1ps

module tb_top
	import tnas_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

	// Four-neighbour frames, mask is {N, W, S, E}
	localparam logic [FRAME_BITS-1:0] EDGE_FRAMES_A [16] = '{
		6'd4, 6'd4, 6'd4, 6'd0, 6'd4, 6'd4, 6'd2, 6'd1,
		6'd4, 6'd6, 6'd4, 6'd3, 6'd8, 6'd7, 6'd5, 6'd4
	};
	localparam logic [FRAME_BITS-1:0] EDGE_FRAMES_B [16] = '{
		6'd15, 6'd12, 6'd3, 6'd0, 6'd14, 6'd13, 6'd2, 6'd1,
		6'd11, 6'd8, 6'd7, 6'd4, 6'd10, 6'd9, 6'd6, 6'd5
	};
	// Blob neighbour byte for each frame number, byte is {NW,N,NE,W,E,SW,S,SE}
	localparam logic [7:0] BLOB_BYTE [48] = '{
		8'h02, 8'h0A, 8'h1A, 8'h12, 8'hDA, 8'h1B, 8'h1E, 8'h7A,
		8'h0B, 8'h5F, 8'h1F, 8'h16, 8'h42, 8'h4A, 8'h5A, 8'h52,
		8'h4B, 8'h7F, 8'hDF, 8'h56, 8'h6B, 8'h7E, 8'h80, 8'hDE,
		8'h40, 8'h48, 8'h58, 8'h50, 8'h6A, 8'hFB, 8'hFE, 8'hD2,
		8'h7B, 8'hFF, 8'hDB, 8'hD6, 8'h00, 8'h08, 8'h18, 8'h10,
		8'h5E, 8'h78, 8'hD8, 8'h5B, 8'h68, 8'hF8, 8'hFA, 8'hD0
	};
	// Neighbour offsets in slot order NW, N, NE, W, E, SW, S, SE
	localparam int NB_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
	localparam int NB_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

	typedef enum {RX_OPEN, RX_SPARSE, RX_COMB, RX_HEAVY} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]   cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	item_t                 offer_item = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [FRAME_BITS-1:0] frame_index;

	// Register copy kept by the predictor
	logic [DIM_BITS-1:0]  cfg_width = WIDTH_RESET;
	logic [DIM_BITS-1:0]  cfg_height = HEIGHT_RESET;
	logic [MODE_BITS-1:0] cfg_mode = MODE_RESET;

	item_t                 tiles_waiting [$];
	logic [FRAME_BITS-1:0] frames_due [$];
	logic [FRAME_BITS-1:0] want;

	int n_queued = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_faults = 0;
	int n_settings = 1;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int long_holds = 0;
	int rx_tick = 0;
	rx_style_t rx_style = RX_OPEN;
	bit calm = 1'b0;

	tile_neighbour_autotile_select_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.tile_x       (offer_item.tile_x),
		.tile_y       (offer_item.tile_y),
		.center_id    (offer_item.center_id),
		.northwest_id (offer_item.nbr_id[NB_NW]),
		.north_id     (offer_item.nbr_id[NB_N]),
		.northeast_id (offer_item.nbr_id[NB_NE]),
		.west_id      (offer_item.nbr_id[NB_W]),
		.east_id      (offer_item.nbr_id[NB_E]),
		.southwest_id (offer_item.nbr_id[NB_SW]),
		.south_id     (offer_item.nbr_id[NB_S]),
		.southeast_id (offer_item.nbr_id[NB_SE]),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_index  (frame_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the frame that one tile should get under the given registers
	function automatic logic [FRAME_BITS-1:0] predict_frame(item_t t,
			logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h, logic [MODE_BITS-1:0] md);
		int x, y, wi, hi, nx, ny, i;
		logic [3:0] mask4;
		logic [7:0] mask8;
		logic [FRAME_BITS-1:0] f;
		x = t.tile_x;
		y = t.tile_y;
		wi = w;
		hi = h;
		mask4 = '0;
		mask8 = '0;
		f = '0;
		if (md == MODE_TABLE_A || md == MODE_TABLE_B) begin
			// edge columns and rows never join, whatever the neighbour ids
			if (x > 0 && x < wi - 1) begin
				mask4[0] = (t.nbr_id[NB_E] == t.center_id);
				mask4[2] = (t.nbr_id[NB_W] == t.center_id);
			end
			if (y > 0 && y < hi - 1) begin
				mask4[1] = (t.nbr_id[NB_S] == t.center_id);
				mask4[3] = (t.nbr_id[NB_N] == t.center_id);
			end
			f = (md == MODE_TABLE_A) ? EDGE_FRAMES_A[mask4] : EDGE_FRAMES_B[mask4];
		end else if (md == MODE_BLOB) begin
			for (i = 0; i < 8; i++) begin
				nx = x + NB_DX[i];
				ny = y + NB_DY[i];
				if (nx >= 0 && nx < wi && ny >= 0 && ny < hi && t.nbr_id[i] == t.center_id)
					mask8[7 - i] = 1'b1;
			end
			// drop a corner unless both of its edges join
			if (!(mask8[6] && mask8[4])) mask8[7] = 1'b0;
			if (!(mask8[6] && mask8[3])) mask8[5] = 1'b0;
			if (!(mask8[4] && mask8[1])) mask8[2] = 1'b0;
			if (!(mask8[1] && mask8[3])) mask8[0] = 1'b0;
			for (i = 0; i < 48; i++)
				if (BLOB_BYTE[i] == mask8)
					f = FRAME_BITS'(i);
		end
		return f;
	endfunction

	// Build a tile whose neighbours equal the center where link_mask has a one
	function automatic item_t make_tile(int x, int y, logic [ID_BITS-1:0] centre,
			logic [7:0] link_mask);
		item_t t;
		int i;
		logic [ID_BITS-1:0] diff;
		t.tile_x = COORD_BITS'(x);
		t.tile_y = COORD_BITS'(y);
		t.center_id = centre;
		for (i = 0; i < 8; i++) begin
			if ($urandom_range(0, 1) == 1)
				diff = ID_BITS'(1) << $urandom_range(0, ID_BITS - 1);
			else
				diff = ID_BITS'($urandom_range(1, 65535));
			t.nbr_id[i] = link_mask[7 - i] ? centre : centre ^ diff;
		end
		return t;
	endfunction

	// Favor the map border and just outside it
	function automatic int pick_coord(logic [DIM_BITS-1:0] dim);
		int d;
		d = dim;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return d - 2;
			3: return d - 1;
			4: return d;
			5: return d + 1;
			6: return 4095;
			7: return $urandom_range(0, 4095);
			default: return (d > 1) ? $urandom_range(0, d - 1) : $urandom_range(0, 3);
		endcase
	endfunction

	function automatic item_t random_tile();
		item_t t;
		int pick, i;
		logic [7:0] link_mask;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			// noise: unrelated ids everywhere
			t.tile_x = COORD_BITS'($urandom);
			t.tile_y = COORD_BITS'($urandom);
			t.center_id = ID_BITS'($urandom);
			for (i = 0; i < 8; i++)
				t.nbr_id[i] = ID_BITS'($urandom);
			return t;
		end
		link_mask = (pick < 5) ? 8'hFF : 8'($urandom);
		return make_tile(pick_coord(cfg_width), pick_coord(cfg_height),
			ID_BITS'($urandom), link_mask);
	endfunction

	task automatic queue_tile(item_t t);
		tiles_waiting.push_back(t);
		n_queued++;
	endtask

	task automatic write_reg(logic [INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MAP_WIDTH: cfg_width = val;
			REG_MAP_HEIGHT: cfg_height = val;
			REG_TILE_MODE: cfg_mode = val[MODE_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued tile has come back, then let the pipeline drain
	task automatic settle();
		do
			@(posedge clk);
		while (n_checked < n_queued);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
			logic [MODE_BITS-1:0] md, int count, bit steady);
		settle();
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
		write_reg(REG_TILE_MODE, CFG_BITS'(md));
		calm = steady;
		n_settings++;
		repeat (count) queue_tile(random_tile());
	endtask

	// Sender: offer queued items in bursts, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				frames_due.push_back(predict_frame(offer_item, cfg_width, cfg_height, cfg_mode));
				n_sent++;
			end
			if (in_valid && in_stall) begin
				// hold the stalled item
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tiles_waiting.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				offer_item <= tiles_waiting.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
		end
	end

	// Receiver: check each frame, stall on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$error("frame_index: expected none, actual %0d", frame_index);
					n_faults++;
				end else begin
					want = frames_due.pop_front();
					n_checked++;
					if (frame_index !== want) begin
						$error("frame_index: expected %0d, actual %0d", want, frame_index);
						n_faults++;
					end
				end
			end
			// long hold-off while a full phase is still queued, so the input backs up
			if (hold_left == 0 && long_holds < 3 && tiles_waiting.size() >= 60) begin
				hold_left = 120;
				long_holds++;
			end
			rx_tick++;
			if (rx_tick % 48 == 0)
				rx_style = rx_style_t'($urandom_range(0, 3));
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm || rx_style == RX_OPEN) begin
				out_stall <= 1'b0;
			end else if (rx_style == RX_SPARSE) begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end else if (rx_style == RX_COMB) begin
				out_stall <= (rx_tick % 8 < 3);
			end else begin
				out_stall <= ($urandom_range(0, 1) == 1);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset registers: blob mode over a 64 by 64 map
		queue_tile(make_tile(10, 10, 16'h1234, 8'hFF));
		queue_tile(make_tile(10, 10, 16'hFFFF, 8'h00));
		queue_tile(make_tile(10, 10, 16'h0000, 8'h1A));
		queue_tile(make_tile(10, 10, 16'hABCD, 8'h80));
		queue_tile(make_tile(20, 30, 16'h0F0F, 8'hA5));
		queue_tile(make_tile(0, 0, 16'h5555, 8'hFF));
		queue_tile(make_tile(63, 63, 16'hAAAA, 8'hFF));
		queue_tile(make_tile(64, 10, 16'h00FF, 8'hFF));
		queue_tile(make_tile(4095, 4095, 16'h0001, 8'hFF));
		queue_tile(make_tile(0, 63, 16'h8000, 8'hFF));

		// Four-neighbour tables with the border columns and rows
		settle();
		write_reg(REG_TILE_MODE, CFG_BITS'(MODE_TABLE_A));
		queue_tile(make_tile(10, 10, 16'h7777, 8'hFF));
		queue_tile(make_tile(0, 10, 16'h7777, 8'hFF));
		queue_tile(make_tile(62, 62, 16'h3C3C, 8'hFF));
		queue_tile(make_tile(63, 10, 16'hC3C3, 8'hFF));
		settle();
		write_reg(REG_TILE_MODE, CFG_BITS'(MODE_TABLE_B));
		queue_tile(make_tile(10, 10, 16'h7777, 8'hFF));
		queue_tile(make_tile(10, 0, 16'h1111, 8'h18));
		queue_tile(make_tile(5, 5, 16'h2222, 8'h00));

		// Unused mode, then an empty map
		settle();
		write_reg(REG_TILE_MODE, CFG_BITS'(MODE_UNUSED));
		queue_tile(make_tile(10, 10, 16'h4444, 8'hFF));
		settle();
		write_reg(REG_TILE_MODE, CFG_BITS'(MODE_BLOB));
		write_reg(REG_MAP_WIDTH, 13'd0);
		queue_tile(make_tile(0, 0, 16'h9999, 8'hFF));
		n_settings += 4;

		// Random traffic over a spread of register settings
		run_phase(13'd64, 13'd64, MODE_BLOB, 100, 1'b0);
		run_phase(13'd1, 13'd1, MODE_BLOB, 40, 1'b0);
		run_phase(13'd4096, 13'd4096, MODE_TABLE_A, 60, 1'b0);
		run_phase(13'd8191, 13'd0, MODE_TABLE_B, 40, 1'b0);
		run_phase(13'd0, 13'd8191, MODE_BLOB, 40, 1'b0);
		run_phase(13'd2, 13'd3, MODE_TABLE_A, 60, 1'b0);
		run_phase(13'd3, 13'd2, MODE_TABLE_B, 60, 1'b1);
		run_phase(13'd4096, 13'd1, MODE_BLOB, 60, 1'b0);
		run_phase(13'd5, 13'd5, MODE_UNUSED, 30, 1'b0);
		for (int k = 0; k < 4; k++)
			run_phase(DIM_BITS'($urandom_range(1, 40)), DIM_BITS'($urandom_range(1, 40)),
				MODE_BITS'($urandom_range(0, 2)), 80, k == 1);

		settle();
		repeat (8) @(posedge clk);
		$display("Classified %0d tiles over %0d register settings: both edge tables,",
			n_sent, n_settings);
		$display("the blob table, the unused mode, map sizes 0 to 8191; %0d long output holds.",
			long_holds);
		if (n_faults == 0 && frames_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
